// ===== hw/rtl/lcr_pkg.sv =====
package lcr_pkg;

  // Field widths of the command and result ports
  localparam int LabelW = 10;
  localparam int DenseW = 10;
  localparam int CountW = 11;

  // Largest dense index that fits the result field
  localparam logic [DenseW-1:0] DenseMax = '1;

  // Command codes
  localparam logic [1:0] OpMark  = 2'd0;
  localparam logic [1:0] OpRenum = 2'd1;
  localparam logic [1:0] OpClear = 2'd2;

  // One word of the label store: presence bit and its rank
  typedef struct packed {
    logic              present;
    logic [DenseW-1:0] rank;
  } entry_t;

endpackage

// ===== hw/rtl/label_compaction_renumber_top.sv =====
// Label compaction: sparse labels are marked, then renumbered onto a dense range.
// A command is transferred when start is high and busy is low. A mark of an
// in-range label holds busy for its mark step after the transfer; the unused op
// code and an out-of-range mark are taken without raising busy. A renumber whose
// ranks are current holds busy for its lookup step and presents its result on
// the result ports in the cycle after it, with valid_o high for that single
// cycle. The receiver cannot stall, so it must take the result as it appears.
// All work goes through one label store with one read and one write port. The
// first renumber after an in-range mark or a clear first runs a prefix-sum pass
// that visits each of the DEPTH entries once, where DEPTH is MAX_LABELS limited
// to 1024, then rereads the label's entry. A clear, and also the start-up after
// reset, sweeps the store one entry a cycle and zeroes all DEPTH entries.
module label_compaction_renumber_top #(
  parameter int MAX_LABELS = 1024
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                op_i,
  input  logic [lcr_pkg::LabelW-1:0] label_i,
  output logic                      valid_o,
  output logic [lcr_pkg::DenseW-1:0] dense_index_o,
  output logic [lcr_pkg::CountW-1:0] aggregate_count_o,
  output logic                      label_marked_o
);

  // Labels are 10 bits, so no more than 1024 entries are ever addressed
  localparam int Depth = (MAX_LABELS < 1024) ? MAX_LABELS : 1024;
  localparam int IdxW  = $clog2(Depth);
  localparam logic [IdxW:0] LastCnt  = (IdxW+1)'(Depth - 1);
  localparam logic [IdxW:0] DepthCnt = (IdxW+1)'(Depth);

  // Sequencer states
  localparam logic [2:0] SClear   = 3'd0;
  localparam logic [2:0] SIdle    = 3'd1;
  localparam logic [2:0] SMark    = 3'd2;
  localparam logic [2:0] SRebuild = 3'd3;
  localparam logic [2:0] SReread  = 3'd4;
  localparam logic [2:0] SLook    = 3'd5;

  logic [2:0]                 state_q, state_d;
  logic [IdxW:0]              cnt_q, cnt_d;
  logic [lcr_pkg::CountW-1:0] run_q, run_d;
  logic [lcr_pkg::CountW-1:0] total_q, total_d;
  logic                       stale_q, stale_d;
  logic [IdxW-1:0]            label_q;
  logic                       in_range_q;
  logic                       valid_q, valid_d;
  logic [lcr_pkg::DenseW-1:0] dense_q, dense_d;
  logic [lcr_pkg::CountW-1:0] count_q;
  logic                       marked_q, marked_d;

  // Store ports
  lcr_pkg::entry_t mem [Depth];
  lcr_pkg::entry_t rd_q;
  lcr_pkg::entry_t wd;
  logic [IdxW-1:0] ra, wa;
  logic            we;
  logic [IdxW:0]   cnt_prev;

  logic accept;
  logic in_range;
  logic [IdxW-1:0] label_idx;

  assign accept    = start && !busy;
  assign in_range  = int'(label_i) < Depth;
  assign label_idx = label_i[IdxW-1:0];
  assign cnt_prev  = cnt_q - 1'b1;

  // Sequencer and store addressing
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    run_d    = run_q;
    total_d  = total_q;
    stale_d  = stale_q;
    valid_d  = 1'b0;
    dense_d  = dense_q;
    marked_d = marked_q;
    ra       = label_idx;
    wa       = label_q;
    wd       = rd_q;
    we       = 1'b0;
    unique case (state_q)
      SClear: begin
        wa = cnt_q[IdxW-1:0];
        wd = '0;
        we = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LastCnt) begin
          state_d = SIdle;
        end
      end
      SIdle: begin
        if (accept) begin
          priority if (op_i == lcr_pkg::OpMark) begin
            if (in_range) begin
              state_d = SMark;
              stale_d = 1'b1;
            end
          end else if (op_i == lcr_pkg::OpRenum) begin
            if (stale_q) begin
              state_d = SRebuild;
              cnt_d   = '0;
              run_d   = '0;
            end else begin
              state_d = SLook;
            end
          end else if (op_i == lcr_pkg::OpClear) begin
            state_d = SClear;
            cnt_d   = '0;
            total_d = '0;
            stale_d = 1'b1;
          end else begin
            state_d = SIdle;
          end
        end
      end
      SMark: begin
        // rank goes stale anyway, only the presence bit matters
        wd.present = 1'b1;
        we = 1'b1;
        if (!rd_q.present) begin
          total_d = total_q + 1'b1;
        end
        state_d = SIdle;
      end
      SRebuild: begin
        // read entry cnt, write the rank of the entry read in the previous step
        ra = cnt_q[IdxW-1:0];
        wa = cnt_prev[IdxW-1:0];
        wd.present = rd_q.present;
        wd.rank    = run_q[lcr_pkg::DenseW-1:0];
        if (cnt_q != '0) begin
          we    = 1'b1;
          run_d = run_q + lcr_pkg::CountW'(rd_q.present);
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DepthCnt) begin
          state_d = SReread;
          stale_d = 1'b0;
        end
      end
      SReread: begin
        ra = label_q;
        state_d = SLook;
      end
      SLook: begin
        valid_d = 1'b1;
        if (in_range_q) begin
          dense_d  = rd_q.rank;
          marked_d = rd_q.present;
        end else begin
          dense_d  = (total_q > lcr_pkg::CountW'(lcr_pkg::DenseMax)) ?
                     lcr_pkg::DenseMax : total_q[lcr_pkg::DenseW-1:0];
          marked_d = 1'b0;
        end
        state_d = SIdle;
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  // Label store, registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[ra];
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClear;
      cnt_q   <= '0;
      total_q <= '0;
      stale_q <= 1'b1;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      total_q <= total_d;
      stale_q <= stale_d;
      valid_q <= valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    run_q    <= run_d;
    dense_q  <= dense_d;
    marked_q <= marked_d;
    if (state_q == SLook) begin
      count_q <= total_q;
    end
    if (accept) begin
      label_q    <= label_idx;
      in_range_q <= in_range;
    end
  end

  assign busy              = (state_q != SIdle);
  assign valid_o           = valid_q;
  assign dense_index_o     = dense_q;
  assign aggregate_count_o = count_q;
  assign label_marked_o    = marked_q;

`ifndef SYNTH
  // A result follows only the lookup step
  a_valid_after_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(state_q) == SLook)
    else $error("result strobe without lookup");

  // Result strobe lasts a single cycle
  a_valid_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("result strobe held");

  // Clear empties the count and starts a sweep
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && op_i == lcr_pkg::OpClear) |=> (total_q == '0 && busy))
    else $error("clear did not reset the count");

  // Never more marked labels than entries
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= lcr_pkg::CountW'(Depth))
    else $error("marked total exceeds store depth");

  // Ranks are current when a lookup reads the store
  a_look_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SLook) |-> !stale_q)
    else $error("lookup on stale ranks");
`endif

endmodule

// ===== sim/label_compaction_renumber_top_tb.sv =====
module label_compaction_renumber_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LabelSpan  = 1024;
  localparam int RandCmds   = 560;
  localparam int FillCmds   = 180;
  localparam int StallLimit = 8000;
  localparam int TailCycles = 16;
  localparam int DirRows    = 25;

  // Op code three is not decoded by the block
  localparam logic [1:0] OpSpare = 2'd3;

  typedef struct packed {
    logic [lcr_pkg::DenseW-1:0] dense;
    logic [lcr_pkg::CountW-1:0] count;
    logic                       marked;
  } renum_result_t;

  typedef struct packed {
    logic [1:0]                 op;
    logic [lcr_pkg::LabelW-1:0] lbl;
    logic                       typed;
    logic [lcr_pkg::DenseW-1:0] dense;
    logic [lcr_pkg::CountW-1:0] count;
    logic                       marked;
  } dir_row_t;

  logic                       clk_i;
  logic                       rst_ni = 1'b0;
  logic                       start = 1'b0;
  logic                       busy;
  logic [1:0]                 op_i = lcr_pkg::OpMark;
  logic [lcr_pkg::LabelW-1:0] label_i = '0;
  logic                       valid_o;
  logic [lcr_pkg::DenseW-1:0] dense_index_o;
  logic [lcr_pkg::CountW-1:0] aggregate_count_o;
  logic                       label_marked_o;

  // Mirror of the label store
  logic                       mark_bits [LabelSpan];
  logic [lcr_pkg::DenseW-1:0] rank_of [LabelSpan];
  logic [lcr_pkg::CountW-1:0] mark_total;
  logic                       ranks_stale;
  int                         peak_total;

  renum_result_t pending_renums[$];
  int            cmds_done;
  int            results_seen;
  int            mismatches;
  bit            gaps_on;

  // Directed commands; typed expectations only where obvious
  dir_row_t dir_rows [DirRows] = '{
    '{lcr_pkg::OpRenum, 10'd0,    1'b1, 10'd0, 11'd0, 1'b0},
    '{lcr_pkg::OpRenum, 10'd1023, 1'b1, 10'd0, 11'd0, 1'b0},
    '{OpSpare,          10'd1023, 1'b0, 10'd0, 11'd0, 1'b0},
    '{lcr_pkg::OpRenum, 10'd1023, 1'b1, 10'd0, 11'd0, 1'b0},
    '{lcr_pkg::OpMark,  10'd0,    1'b0, 10'd0, 11'd0, 1'b0},
    '{lcr_pkg::OpMark,  10'd1023, 1'b0, 10'd0, 11'd0, 1'b0},
    '{lcr_pkg::OpRenum, 10'd1023, 1'b1, 10'd1, 11'd2, 1'b1},
    '{lcr_pkg::OpRenum, 10'd0,    1'b1, 10'd0, 11'd2, 1'b1},
    '{lcr_pkg::OpMark,  10'd1023, 1'b0, 10'd0, 11'd0, 1'b0},
    '{lcr_pkg::OpRenum, 10'd1023, 1'b1, 10'd1, 11'd2, 1'b1},
    '{lcr_pkg::OpRenum, 10'd512,  1'b1, 10'd1, 11'd2, 1'b0},
    '{lcr_pkg::OpMark,  10'h2AA,  1'b0, 10'd0, 11'd0, 1'b0},
    '{lcr_pkg::OpMark,  10'h155,  1'b0, 10'd0, 11'd0, 1'b0},
    '{lcr_pkg::OpRenum, 10'h2AA,  1'b0, 10'd0, 11'd0, 1'b0},
    '{lcr_pkg::OpRenum, 10'h155,  1'b0, 10'd0, 11'd0, 1'b0},
    '{lcr_pkg::OpRenum, 10'd1022, 1'b0, 10'd0, 11'd0, 1'b0},
    '{OpSpare,          10'h155,  1'b0, 10'd0, 11'd0, 1'b0},
    '{lcr_pkg::OpClear, 10'h3FF,  1'b0, 10'd0, 11'd0, 1'b0},
    '{lcr_pkg::OpRenum, 10'h2AA,  1'b1, 10'd0, 11'd0, 1'b0},
    '{lcr_pkg::OpMark,  10'd1,    1'b0, 10'd0, 11'd0, 1'b0},
    '{lcr_pkg::OpClear, 10'd0,    1'b0, 10'd0, 11'd0, 1'b0},
    '{lcr_pkg::OpRenum, 10'd1,    1'b1, 10'd0, 11'd0, 1'b0},
    '{lcr_pkg::OpMark,  10'd1023, 1'b0, 10'd0, 11'd0, 1'b0},
    '{lcr_pkg::OpRenum, 10'd1023, 1'b1, 10'd0, 11'd1, 1'b1},
    '{lcr_pkg::OpRenum, 10'd1022, 1'b1, 10'd0, 11'd1, 1'b0}
  };

  label_compaction_renumber_top #(
    .MAX_LABELS(LabelSpan)
  ) uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .op_i              (op_i),
    .label_i           (label_i),
    .valid_o           (valid_o),
    .dense_index_o     (dense_index_o),
    .aggregate_count_o (aggregate_count_o),
    .label_marked_o    (label_marked_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Exclusive prefix sum over the presence bits
  function automatic void refresh_ranks();
    logic [lcr_pkg::CountW-1:0] run;
    run = '0;
    for (int i = 0; i < LabelSpan; i++) begin
      rank_of[i] = run[lcr_pkg::DenseW-1:0];
      run = run + lcr_pkg::CountW'(mark_bits[i]);
    end
    ranks_stale = 1'b0;
  endfunction

  // Applies one command to the mirror and gives the renumber result, if any
  function automatic bit predict_cmd(input logic [1:0] op,
                                     input logic [lcr_pkg::LabelW-1:0] lbl,
                                     output renum_result_t res);
    bit in_span;
    in_span = int'(lbl) < LabelSpan;
    res = '0;
    case (op)
      lcr_pkg::OpMark: begin
        if (in_span) begin
          if (!mark_bits[lbl]) begin
            mark_bits[lbl] = 1'b1;
            mark_total = mark_total + 1'b1;
            if (int'(mark_total) > peak_total) peak_total = int'(mark_total);
          end
          ranks_stale = 1'b1;
        end
        return 1'b0;
      end
      lcr_pkg::OpClear: begin
        foreach (mark_bits[i]) mark_bits[i] = 1'b0;
        mark_total = '0;
        ranks_stale = 1'b1;
        return 1'b0;
      end
      lcr_pkg::OpRenum: begin
        if (ranks_stale) refresh_ranks();
        if (in_span) begin
          res.dense  = rank_of[lbl];
          res.marked = mark_bits[lbl];
        end else begin
          res.dense  = (mark_total > lcr_pkg::CountW'(lcr_pkg::DenseMax)) ?
                       lcr_pkg::DenseMax : mark_total[lcr_pkg::DenseW-1:0];
          res.marked = 1'b0;
        end
        res.count = mark_total;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Drives one command, waits for its transfer, then maybe idles
  task automatic send_cmd(input logic [1:0] op, input logic [lcr_pkg::LabelW-1:0] lbl,
                          input bit typed, input renum_result_t typed_res);
    renum_result_t res;
    start   <= 1'b1;
    op_i    <= op;
    label_i <= lbl;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    cmds_done++;
    if (predict_cmd(op, lbl, res)) pending_renums.push_back(typed ? typed_res : res);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  function automatic logic [lcr_pkg::LabelW-1:0] pick_label();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return lcr_pkg::LabelW'($urandom_range(0, LabelSpan - 1));
    endcase
  endfunction

  // Result check against the oldest expectation
  always @(posedge clk_i) begin : check_results
    renum_result_t want;
    if (rst_ni && valid_o) begin
      results_seen++;
      if (pending_renums.size() == 0) begin
        if (mismatches < 10)
          $display("[%0t] result with nothing expected: dense %0d count %0d marked %0b",
                   $realtime, dense_index_o, aggregate_count_o, label_marked_o);
        mismatches++;
      end else begin
        want = pending_renums.pop_front();
        if (dense_index_o !== want.dense || aggregate_count_o !== want.count ||
            label_marked_o !== want.marked) begin
          if (mismatches < 10)
            $display("[%0t] renumber mismatch: dense %0d/%0d count %0d/%0d marked %0b/%0b",
                     $realtime, want.dense, dense_index_o, want.count, aggregate_count_o,
                     want.marked, label_marked_o);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin : watchdog
    int idle_run;
    int last_cmds;
    int last_results;
    if (cmds_done != last_cmds || results_seen != last_results) idle_run = 0;
    else idle_run++;
    last_cmds    = cmds_done;
    last_results = results_seen;
    if (idle_run >= StallLimit) begin
      $display("[%0t] no transfer for %0d cycles", $realtime, StallLimit);
      $display("label_compaction_renumber_top: mismatch");
      $finish;
    end
  end

  initial begin : stimulus
    logic [lcr_pkg::LabelW-1:0] marked_here[$];
    int                         order [LabelSpan];
    int                         rand_cmds;
    int                         grp;
    int                         n;
    int                         j;
    int                         tmp;
    logic [lcr_pkg::LabelW-1:0] lbl;

    foreach (mark_bits[i]) begin
      mark_bits[i] = 1'b0;
      rank_of[i]   = '0;
    end
    mark_total  = '0;
    ranks_stale = 1'b1;
    peak_total  = 0;
    gaps_on     = 1'b1;
    rand_cmds   = 0;
    grp         = 0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    foreach (dir_rows[r])
      send_cmd(dir_rows[r].op, dir_rows[r].lbl, dir_rows[r].typed,
               '{dir_rows[r].dense, dir_rows[r].count, dir_rows[r].marked});

    // Random groups: an occasional clear, a mark burst, then a renumber burst, with spare ops and extra marks mixed in
    while (rand_cmds < RandCmds) begin
      gaps_on = (grp % 5) != 4;
      marked_here.delete();
      if ($urandom_range(0, 3) == 0) begin
        send_cmd(lcr_pkg::OpClear, pick_label(), 1'b0, '0);
        rand_cmds++;
      end
      n = $urandom_range(1, 16);
      repeat (n) begin
        lbl = pick_label();
        marked_here.push_back(lbl);
        send_cmd(lcr_pkg::OpMark, lbl, 1'b0, '0);
        rand_cmds++;
        if ($urandom_range(0, 9) == 0) send_cmd(OpSpare, pick_label(), 1'b0, '0);
      end
      n = $urandom_range(1, 16);
      repeat (n) begin
        case ($urandom_range(0, 15))
          0: begin
            send_cmd(lcr_pkg::OpMark, pick_label(), 1'b0, '0);
            rand_cmds++;
          end
          1: send_cmd(OpSpare, pick_label(), 1'b0, '0);
          default: ;
        endcase
        if ($urandom_range(0, 1) == 0)
          lbl = marked_here[$urandom_range(0, marked_here.size() - 1)];
        else
          lbl = pick_label();
        send_cmd(lcr_pkg::OpRenum, lbl, 1'b0, '0);
        rand_cmds++;
      end
      grp++;
    end

    // Closing stretch without gaps: a shuffled fill of distinct labels, then lookups and one more mark
    gaps_on = 1'b0;
    send_cmd(lcr_pkg::OpClear, '0, 1'b0, '0);
    for (int i = 0; i < LabelSpan; i++) order[i] = i;
    for (int i = LabelSpan - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < FillCmds; i++)
      send_cmd(lcr_pkg::OpMark, lcr_pkg::LabelW'(order[i]), 1'b0, '0);
    send_cmd(lcr_pkg::OpRenum, '1, 1'b0, '0);
    send_cmd(lcr_pkg::OpRenum, '0, 1'b0, '0);
    send_cmd(lcr_pkg::OpMark, '1, 1'b0, '0);
    repeat (8) send_cmd(lcr_pkg::OpRenum, pick_label(), 1'b0, '0);
    start <= 1'b0;

    // Drain
    while (pending_renums.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (pending_renums.size() != 0) mismatches++;

    $display("Transferred %0d commands over %0d random groups plus a gap-free fill;",
             cmds_done, grp);
    $display("checked %0d renumber results, peak aggregate count %0d, %0d mismatches.",
             results_seen, peak_total, mismatches);
    if (mismatches == 0) begin
      $display("label_compaction_renumber_top: match");
    end else begin
      $display("label_compaction_renumber_top: mismatch");
    end
    $finish;
  end

endmodule
